@@ design/vote_window_byte_receiver_core_assert.svh @@
// Assertion macros for the vote window byte receiver.
// Used by the checker that is bound to the top level; no other dependencies.
`ifndef VOTE_WINDOW_BYTE_RECEIVER_CORE_ASSERT_SVH
`define VOTE_WINDOW_BYTE_RECEIVER_CORE_ASSERT_SVH

// Check on every clock edge outside of reset.
`define VWBR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("vwbr assertion failed");

// Check on every clock edge, reset included.
`define VWBR_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("vwbr assertion failed during reset");

`endif

@@ design/vwbr_pkg.sv @@
// Shared types and constants for the vote window byte receiver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package vwbr_pkg;

  // Field and register widths
  localparam int unsigned LINE_COUNT = 8;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned STREAK_W   = 8;
  localparam int unsigned ATTEMPT_W  = 24;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values
  localparam logic [CNT_W-1:0]     WINDOW_LENGTH_RST  = 10'd100;
  localparam logic [CNT_W-1:0]     MIN_VALID_HITS_RST = 10'd50;
  localparam logic [STREAK_W-1:0]  DROP_STREAK_RST    = 8'd10;
  localparam logic [ATTEMPT_W-1:0] DROP_CAP_RST       = 24'd2000000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LENGTH  = 8'd0,
    CFG_MIN_VALID_HITS = 8'd1,
    CFG_DROP_STREAK    = 8'd2,
    CFG_DROP_CAP       = 8'd3
  } cfg_idx_e;

  // Receiver phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_WINDOW = 2'd1,
    PH_DROP   = 2'd2
  } phase_e;

  // Control from the sequencer to the vote counter bank
  typedef struct packed {
    logic clear;
    logic count;
  } vwbr_bank_ctrl_t;

endpackage

`default_nettype wire

@@ design/vwbr_vote_bank.sv @@
// Per-line vote counters and the three-quarter majority decision.
// Depends on vwbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vwbr_vote_bank #(
  parameter int unsigned LineCount = vwbr_pkg::LINE_COUNT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire vwbr_pkg::vwbr_bank_ctrl_t     ctrl_i,
  input  wire logic [vwbr_pkg::BYTE_W-1:0]   data_i,
  input  wire logic [vwbr_pkg::CNT_W-1:0]    hits_i,
  output logic      [vwbr_pkg::BYTE_W-1:0]   byte_o
);
  import vwbr_pkg::*;

  // Only the first eight lines can ever vote
  localparam int unsigned UsedLines = (LineCount < BYTE_W) ? LineCount : BYTE_W;

  logic [CNT_W-1:0]   votes_q   [UsedLines];
  logic [CNT_W-1:0]   votes_upd [UsedLines];
  logic [CNT_W-1:0]   votes_d   [UsedLines];
  logic [CNT_W+1:0]   hits_x3;

  // hits * 3 as hits + 2 * hits
  assign hits_x3 = {2'b00, hits_i} + {1'b0, hits_i, 1'b0};

  for (genvar i = 0; i < BYTE_W; i++) begin : g_line
    if (i < UsedLines) begin : g_used
      // Advance the counter on a strobe sample when the line is active
      assign votes_upd[i] = ctrl_i.count ? (votes_q[i] + {{(CNT_W-1){1'b0}}, data_i[i]})
                                         : votes_q[i];
      assign votes_d[i]   = ctrl_i.clear ? '0 : votes_upd[i];
      // Set the bit when votes * 4 > hits * 3
      assign byte_o[i]    = {votes_upd[i], 2'b00} > hits_x3;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          votes_q[i] <= '0;
        end else begin
          votes_q[i] <= votes_d[i];
        end
      end
    end else begin : g_unused
      assign byte_o[i] = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ design/vote_window_byte_receiver_core.sv @@
// The byte is registered and shown on the output in the cycle after the last sample of
// its window is accepted. Throughput: one sample per cycle; the single output register
// only stalls input while a result waits and out_ready_i is low.
// Reset: asynchronous, active low; configuration registers return to their defaults, the
// receiver goes idle and no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module vote_window_byte_receiver_core #(
  parameter int unsigned LineCount = vwbr_pkg::LINE_COUNT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [vwbr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [vwbr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // sample input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              strobe_active_i,
  input  wire logic [vwbr_pkg::BYTE_W-1:0]       data_active_i,
  // result output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [vwbr_pkg::BYTE_W-1:0]       received_byte_o,
  output logic      [vwbr_pkg::CNT_W-1:0]        window_hits_o
);
  import vwbr_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0]     win_len_q;
  logic [CNT_W-1:0]     min_hits_q;
  logic [STREAK_W-1:0]  streak_need_q;
  logic [ATTEMPT_W-1:0] attempt_cap_q;

  // Receiver state
  phase_e               phase_q, phase_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     hits_q, hits_d;
  logic [STREAK_W-1:0]  streak_q, streak_d;
  logic [ATTEMPT_W-1:0] attempts_q, attempts_d;

  // Output register
  logic                 out_valid_q;
  logic [BYTE_W-1:0]    byte_q;
  logic [CNT_W-1:0]     out_hits_q;

  logic                 in_acc;
  logic                 emit;
  vwbr_bank_ctrl_t      bank_ctrl;
  logic [BYTE_W-1:0]    bank_byte;
  logic [CNT_W-1:0]     win_len_eff;
  logic [STREAK_W-1:0]  streak_need_eff;
  logic [ATTEMPT_W-1:0] attempt_cap_eff;
  logic [CNT_W-1:0]     hits_inc;
  logic [CNT_W-1:0]     idx_inc;
  logic [STREAK_W-1:0]  streak_sat;
  logic [ATTEMPT_W-1:0] attempts_sat;
  logic                 low_done;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q     <= WINDOW_LENGTH_RST;
      min_hits_q    <= MIN_VALID_HITS_RST;
      streak_need_q <= DROP_STREAK_RST;
      attempt_cap_q <= DROP_CAP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WINDOW_LENGTH:  win_len_q     <= cfg_data_i[CNT_W-1:0];
        CFG_MIN_VALID_HITS: min_hits_q    <= cfg_data_i[CNT_W-1:0];
        CFG_DROP_STREAK:    streak_need_q <= cfg_data_i[STREAK_W-1:0];
        CFG_DROP_CAP:       attempt_cap_q <= cfg_data_i[ATTEMPT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero window length, drop streak and drop cap settings behave as one
  assign win_len_eff     = (win_len_q == '0) ? CNT_W'(1) : win_len_q;
  assign streak_need_eff = (streak_need_q == '0) ? STREAK_W'(1) : streak_need_q;
  assign attempt_cap_eff = (attempt_cap_q == '0) ? ATTEMPT_W'(1) : attempt_cap_q;

  assign hits_inc     = hits_q + {{(CNT_W-1){1'b0}}, strobe_active_i};
  assign idx_inc      = idx_q + CNT_W'(1);
  assign streak_sat   = (streak_q == '1) ? streak_q : streak_q + STREAK_W'(1);
  assign attempts_sat = (attempts_q == '1) ? attempts_q : attempts_q + ATTEMPT_W'(1);
  assign low_done     = !strobe_active_i && (streak_sat >= streak_need_eff);

  // Sequence the phases for each accepted sample
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    hits_d     = hits_q;
    streak_d   = streak_q;
    attempts_d = attempts_q;
    emit       = 1'b0;
    bank_ctrl  = '0;
    case (phase_q)
      PH_IDLE: begin
        if (in_acc && strobe_active_i) begin
          phase_d         = PH_WINDOW;
          idx_d           = '0;
          hits_d          = '0;
          bank_ctrl.clear = 1'b1;
        end
      end
      PH_WINDOW: begin
        if (in_acc) begin
          bank_ctrl.count = strobe_active_i;
          hits_d          = hits_inc;
          idx_d           = idx_inc;
          if (idx_inc >= win_len_eff) begin
            if (hits_inc > min_hits_q) begin
              emit       = 1'b1;
              streak_d   = '0;
              attempts_d = '0;
              phase_d    = PH_DROP;
            end else begin
              phase_d = PH_IDLE;
            end
          end
        end
      end
      PH_DROP: begin
        if (in_acc) begin
          streak_d = strobe_active_i ? '0 : streak_sat;
          if (low_done) begin
            phase_d = PH_IDLE;
          end else begin
            attempts_d = attempts_sat;
            if (attempts_sat >= attempt_cap_eff) begin
              phase_d = PH_IDLE;
            end
          end
        end
      end
      default: begin
        if (in_acc) begin
          phase_d = PH_IDLE;
        end
      end
    endcase
  end

  // Hold receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      idx_q      <= '0;
      hits_q     <= '0;
      streak_q   <= '0;
      attempts_q <= '0;
    end else begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      hits_q     <= hits_d;
      streak_q   <= streak_d;
      attempts_q <= attempts_d;
    end
  end

  vwbr_vote_bank #(
    .LineCount(LineCount)
  ) u_vote_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (bank_ctrl),
    .data_i (data_active_i),
    .hits_i (hits_inc),
    .byte_o (bank_byte)
  );

  // Load the result on a decision, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q     <= bank_byte;
      out_hits_q <= hits_inc;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign received_byte_o = byte_q;
  assign window_hits_o   = out_hits_q;

endmodule

`default_nettype wire

@@ design/vwbr_checker.sv @@
// Port-level checks for the vote window byte receiver, bound to the top level.
// Depends on vwbr_pkg and vote_window_byte_receiver_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "vote_window_byte_receiver_core_assert.svh"

module vwbr_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic [vwbr_pkg::BYTE_W-1:0]       received_byte_o,
  input wire logic [vwbr_pkg::CNT_W-1:0]        window_hits_o
);

  // A stalled result transaction holds its payload
  `VWBR_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=>
               out_valid_o && $stable(received_byte_o) && $stable(window_hits_o))

  // An empty output register never blocks input
  `VWBR_ASSERT(a_in_ready_free, !out_valid_o |-> in_ready_o)

  // A new result follows an accepted sample transaction
  `VWBR_ASSERT(a_out_cause, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))

  // An emitted window always saw at least one strobe sample
  `VWBR_ASSERT(a_hits_nonzero, out_valid_o |-> window_hits_o != '0)

  // No result is pending while reset is held
  `VWBR_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o)

endmodule

bind vote_window_byte_receiver_core vwbr_checker u_vwbr_checker (.*);

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for vote_window_byte_receiver_core: drives samples and register
// writes, predicts decoded bytes in a scoreboard class and checks every result transaction.
// Depends on vwbr_pkg and the vote_window_byte_receiver_core RTL.
`timescale 1ns / 1ps

module testbench;
  import vwbr_pkg::*;

  // Predict window votes and decoded bytes; hold expected results in order
  class vote_byte_scoreboard;
    logic [CNT_W-1:0]     win_len;
    logic [CNT_W-1:0]     min_hits;
    logic [STREAK_W-1:0]  streak_need;
    logic [ATTEMPT_W-1:0] attempt_cap;
    phase_e               phase;
    logic [CNT_W-1:0]     sample_idx;
    logic [CNT_W-1:0]     hits;
    logic [CNT_W-1:0]     votes [LINE_COUNT];
    logic [STREAK_W-1:0]  low_run;
    logic [ATTEMPT_W-1:0] attempts;
    logic [BYTE_W-1:0]    byte_q [$];
    logic [CNT_W-1:0]     hits_q [$];
    int                   errors;

    function new();
      win_len     = WINDOW_LENGTH_RST;
      min_hits    = MIN_VALID_HITS_RST;
      streak_need = DROP_STREAK_RST;
      attempt_cap = DROP_CAP_RST;
      phase       = PH_IDLE;
      sample_idx  = '0;
      hits        = '0;
      foreach (votes[i]) votes[i] = '0;
      low_run     = '0;
      attempts    = '0;
      errors      = 0;
    endfunction

    function void write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_WINDOW_LENGTH:  win_len     = val[CNT_W-1:0];
        CFG_MIN_VALID_HITS: min_hits    = val[CNT_W-1:0];
        CFG_DROP_STREAK:    streak_need = val[STREAK_W-1:0];
        CFG_DROP_CAP:       attempt_cap = val[ATTEMPT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the receiver by one accepted sample transaction
    function void note_sample(input logic strobe, input logic [BYTE_W-1:0] data);
      int unsigned len;
      int unsigned need;
      int unsigned cap_eff;
      logic [BYTE_W-1:0] decoded;
      case (phase)
        PH_IDLE: begin
          // the start sample opens the window but is not counted in it
          if (strobe) begin
            sample_idx = '0;
            hits       = '0;
            foreach (votes[i]) votes[i] = '0;
            phase      = PH_WINDOW;
          end
        end
        PH_WINDOW: begin
          len = (win_len == 0) ? 1 : win_len;
          if (strobe) begin
            hits = hits + 1'b1;
            for (int i = 0; i < LINE_COUNT; i++) begin
              if (data[i]) votes[i] = votes[i] + 1'b1;
            end
          end
          sample_idx = sample_idx + 1'b1;
          if (sample_idx >= len) begin
            // decide on the last sample: three-quarter majority per line
            if (hits > min_hits) begin
              decoded = '0;
              for (int i = 0; i < BYTE_W; i++) begin
                decoded[i] = (int'(votes[i]) * 4) > (int'(hits) * 3);
              end
              byte_q.push_back(decoded);
              hits_q.push_back(hits);
              low_run  = '0;
              attempts = '0;
              phase    = PH_DROP;
            end else begin
              phase = PH_IDLE;
            end
          end
        end
        PH_DROP: begin
          need    = (streak_need == 0) ? 1 : streak_need;
          cap_eff = (attempt_cap == 0) ? 1 : attempt_cap;
          if (!strobe) begin
            if (low_run != '1) low_run = low_run + 1'b1;
            if (low_run >= need) begin
              phase = PH_IDLE;
              return;
            end
          end else begin
            low_run = '0;
          end
          if (attempts != '1) attempts = attempts + 1'b1;
          if (attempts >= cap_eff) phase = PH_IDLE;
        end
        default: phase = PH_IDLE;
      endcase
    endfunction

    // Compare one result transaction with the oldest expected byte
    function void check_result(input logic [BYTE_W-1:0] got_byte,
                               input logic [CNT_W-1:0] got_hits);
      logic [BYTE_W-1:0] exp_byte;
      logic [CNT_W-1:0]  exp_hits;
      if (byte_q.size() == 0) begin
        $display("%0t: unexpected result, received_byte %h window_hits %0d",
                 $time, got_byte, got_hits);
        errors++;
        return;
      end
      exp_byte = byte_q.pop_front();
      exp_hits = hits_q.pop_front();
      if (got_byte !== exp_byte) begin
        $display("%0t: received_byte expected %h actual %h", $time, exp_byte, got_byte);
        errors++;
      end
      if (got_hits !== exp_hits) begin
        $display("%0t: window_hits expected %0d actual %0d", $time, exp_hits, got_hits);
        errors++;
      end
    endfunction

    function int pending();
      return byte_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  strobe_active_i;
  logic [BYTE_W-1:0]     data_active_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [BYTE_W-1:0]     received_byte_o;
  logic [CNT_W-1:0]      window_hits_o;

  vote_byte_scoreboard sb;
  int snd_idle_pct = 36;
  int rcv_idle_pct = 64;
  int samples_sent = 0;

  vote_window_byte_receiver_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .strobe_active_i (strobe_active_i),
    .data_active_i   (data_active_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .received_byte_o (received_byte_o),
    .window_hits_o   (window_hits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stall the result channel at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Check each result transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(received_byte_o, window_hits_o);
    end
  end

  // Send one sample; starts and ends at a falling edge with valid dropped
  task automatic push_sample(input logic strobe, input logic [BYTE_W-1:0] data);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    strobe_active_i = strobe;
    data_active_i   = data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_sample(strobe, data);
    samples_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Hold the sender until every expected byte is out, then let the pipe empty
  task automatic settle_results();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apply_setting(input int wl, input int mh, input int sn, input int cap);
    settle_results();
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(wl));
    write_reg(CFG_MIN_VALID_HITS, CFG_DATA_W'(mh));
    write_reg(CFG_DROP_STREAK, CFG_DATA_W'(sn));
    write_reg(CFG_DROP_CAP, CFG_DATA_W'(cap));
  endtask

  // One frame: idle noise, start, a window around a byte pattern, then the drop wait
  task automatic run_frame();
    logic [BYTE_W-1:0] pattern;
    logic [BYTE_W-1:0] flips;
    int strobe_pct;
    int flip_pct;
    int noise_len;
    int n;
    pattern = BYTE_W'($urandom);
    case ($urandom_range(0, 3))
      0: strobe_pct = 100;
      1: strobe_pct = 90;
      2: strobe_pct = 60;
      default: strobe_pct = 30;
    endcase
    case ($urandom_range(0, 3))
      0: flip_pct = 0;
      1: flip_pct = 10;
      2: flip_pct = 25;
      default: flip_pct = 50;
    endcase
    repeat ($urandom_range(0, 2)) push_sample(1'b0, BYTE_W'($urandom));
    push_sample(1'b1, BYTE_W'($urandom));
    while (sb.phase == PH_WINDOW) begin
      for (int b = 0; b < BYTE_W; b++) flips[b] = ($urandom_range(0, 99) < flip_pct);
      push_sample($urandom_range(0, 99) < strobe_pct, pattern ^ flips);
    end
    // bounce the strobe a little, then drop it
    noise_len = $urandom_range(0, 6);
    n = 0;
    while (sb.phase == PH_DROP) begin
      push_sample((n < noise_len) ? 1'($urandom_range(0, 1)) : 1'b0, BYTE_W'($urandom));
      n++;
    end
  endtask

  task automatic run_segment(input int wl, input int mh, input int sn, input int cap,
                             input int budget);
    int start_count;
    apply_setting(wl, mh, sn, cap);
    start_count = samples_sent;
    do begin
      run_frame();
      if ($urandom_range(0, 9) == 0) settle_results();
    end while (samples_sent - start_count < budget);
  endtask

  initial begin
    int wl;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_WINDOW_LENGTH;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    strobe_active_i = 1'b0;
    data_active_i   = '0;
    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Zero window length, drop streak and drop cap act as one
    apply_setting(0, 0, 0, 0);
    push_sample(1'b0, 8'hFF);  // ignored while idle
    push_sample(1'b1, 8'hFF);  // start sample, not counted
    push_sample(1'b1, 8'hFF);  // one-sample window decides at once
    push_sample(1'b1, 8'h00);  // attempt cap of one ends the drop wait
    push_sample(1'b1, 8'h00);
    push_sample(1'b0, 8'hFF);  // no hits: back to idle, no byte
    push_sample(1'b1, 8'h00);
    push_sample(1'b1, 8'h00);  // all-zero byte
    push_sample(1'b0, 8'h00);  // first low sample ends the drop wait

    // Vote threshold edge: 4 of 4 sets the bit, 3 of 4 does not
    apply_setting(4, 3, 2, 3);
    push_sample(1'b1, 8'h00);
    push_sample(1'b1, 8'h0F);
    push_sample(1'b1, 8'h07);
    push_sample(1'b1, 8'h03);
    push_sample(1'b1, 8'h01);
    push_sample(1'b1, 8'hAA);  // drop wait ended by the attempt cap
    push_sample(1'b0, 8'h55);
    push_sample(1'b1, 8'hFF);
    // Hits equal to the minimum: no byte
    push_sample(1'b1, 8'hFF);
    push_sample(1'b1, 8'hFF);
    push_sample(1'b0, 8'hFF);
    push_sample(1'b1, 8'hFF);
    push_sample(1'b1, 8'hFF);

    // Sender idles less than the receiver
    run_segment(WINDOW_LENGTH_RST, MIN_VALID_HITS_RST, DROP_STREAK_RST, DROP_CAP_RST, 100);
    wl = $urandom_range(1, 12);
    run_segment(wl, $urandom_range(0, wl - 1), $urandom_range(1, 4), $urandom_range(1, 8),
                120);
    run_segment(8, 1023, 1, 1, 40);

    // Receiver idles less than the sender
    snd_idle_pct = 64;
    rcv_idle_pct = 36;
    run_segment(0, 0, 0, 0, 60);
    run_segment(1023, 0, 3, 16777215, 1);
    wl = $urandom_range(2, 20);
    run_segment(wl, $urandom_range(0, wl - 1), 255, 16777215, 1);

    // Full rate both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    wl = $urandom_range(1, 16);
    run_segment(wl, $urandom_range(0, wl), $urandom_range(1, 6), $urandom_range(1, 20), 100);
    wl = 4 * $urandom_range(1, 4);
    run_segment(wl, $urandom_range(0, wl / 2), $urandom_range(1, 3), $urandom_range(2, 30),
                100);

    settle_results();
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("vote_window_byte_receiver_core verification clean");
    end else begin
      $display("vote_window_byte_receiver_core verification failed");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #4_800_000;
    $display("vote_window_byte_receiver_core verification failed");
    $finish;
  end

endmodule
